### sv/ccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared codes, widths and helpers for the circle collision response block.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_PEG  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NOP  = 2'd3
  } ccr_mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_X    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_Y    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC     = 4'd7;

  // (1 + 0.9) / 2 in Q6.30
  localparam logic signed [35:0] RESTIT_HALF_Q30 = 36'sd1020054733;

  localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

  typedef struct packed {
    logic               hit;
    logic               peg_moving_out;
    logic signed [31:0] peg_vel_out_x;
    logic signed [31:0] peg_vel_out_y;
    logic signed [31:0] ball_pos_out_x;
    logic signed [31:0] ball_pos_out_y;
    logic signed [31:0] ball_vel_out_x;
    logic signed [31:0] ball_vel_out_y;
    logic [15:0]        hits_total;
  } ccr_res_t;

  typedef enum logic [35:0] {
    S_IDLE = 36'd1 << 0,
    S_DONE = 36'd1 << 1,
    S_T0   = 36'd1 << 2,
    S_T1   = 36'd1 << 3,
    S_T2   = 36'd1 << 4,
    S_T3   = 36'd1 << 5,
    S_T4   = 36'd1 << 6,
    S_T5   = 36'd1 << 7,
    S_T6   = 36'd1 << 8,
    S_T7   = 36'd1 << 9,
    S_P0   = 36'd1 << 10,
    S_P1   = 36'd1 << 11,
    S_P2   = 36'd1 << 12,
    S_P3   = 36'd1 << 13,
    S_P4   = 36'd1 << 14,
    S_P5   = 36'd1 << 15,
    S_P6   = 36'd1 << 16,
    S_P7   = 36'd1 << 17,
    S_P8   = 36'd1 << 18,
    S_NORM = 36'd1 << 19,
    S_SQ0  = 36'd1 << 20,
    S_SQ1  = 36'd1 << 21,
    S_SQ2  = 36'd1 << 22,
    S_ROOT = 36'd1 << 23,
    S_DIV  = 36'd1 << 24,
    S_D0   = 36'd1 << 25,
    S_D1   = 36'd1 << 26,
    S_D2   = 36'd1 << 27,
    S_D3   = 36'd1 << 28,
    S_D4   = 36'd1 << 29,
    S_D5   = 36'd1 << 30,
    S_D6   = 36'd1 << 31,
    S_D7   = 36'd1 << 32,
    S_D8   = 36'd1 << 33,
    S_D9   = 36'd1 << 34,
    S_D10  = 36'd1 << 35
  } ccr_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFFFFFF;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round to nearest, ties up, dropping 30 fraction bits
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    logic signed [71:0] s;
    s = v + 72'sd536870912;
    return s >>> 30;
  endfunction

endpackage

### sv/ccr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface ccr_in_if;
  logic                           valid;
  logic                           ready;
  logic [ccr_pkg::MODE_W-1:0]     mode;
  logic signed [31:0]             pos_x;
  logic signed [31:0]             pos_y;
  logic signed [31:0]             vel_x;
  logic signed [31:0]             vel_y;
  logic [9:0]                     peg_radius_px;
  logic                           peg_inside;
  logic                           peg_moving;
  logic                           last_peg;
  logic [15:0]                    time_step;

  modport source (output valid, mode, pos_x, pos_y, vel_x, vel_y, peg_radius_px,
                  peg_inside, peg_moving, last_peg, time_step, input ready);
  modport sink (input valid, mode, pos_x, pos_y, vel_x, vel_y, peg_radius_px,
                peg_inside, peg_moving, last_peg, time_step, output ready);
endinterface

interface ccr_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               peg_moving_out;
  logic signed [31:0] peg_vel_out_x;
  logic signed [31:0] peg_vel_out_y;
  logic signed [31:0] ball_pos_out_x;
  logic signed [31:0] ball_pos_out_y;
  logic signed [31:0] ball_vel_out_x;
  logic signed [31:0] ball_vel_out_y;
  logic [15:0]        hits_total;

  modport source (output valid, hit, peg_moving_out, peg_vel_out_x, peg_vel_out_y,
                  ball_pos_out_x, ball_pos_out_y, ball_vel_out_x, ball_vel_out_y,
                  hits_total, input ready);
  modport sink (input valid, hit, peg_moving_out, peg_vel_out_x, peg_vel_out_y,
                ball_pos_out_x, ball_pos_out_y, ball_vel_out_x, ball_vel_out_y,
                hits_total, output ready);
endinterface

interface ccr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ccr_pkg::CFG_IDX_W-1:0] index;
  logic [ccr_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/circle_collision_response.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_collision_response
// One ball against a scan of circular pegs, with a restitution impulse.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready while it works on it.
// A load, an unused mode, a skipped peg or a zero time tick goes straight to
// the result; a time tick runs through states T0 to T7; a peg that is tested
// runs P0 to P5 and stops there when one axis alone is out of reach, else
// goes on to P8. A hit then reduces the normal, squares it, takes a bit-serial
// square root and two restoring divisions, then computes the impulse. One
// 36x36 multiplier is shared by the steps, and one 65-bit subtractor by the
// square root and the divisions. A finished result waits in the output
// register while the next item is taken.
module circle_collision_response #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ccr_in_if.sink     in_ch,
  ccr_out_if.source  out_ch,
  ccr_cfg_if.sink    cfg_ch
);

  ccr_pkg::ccr_state_t state_r, state_nxt;

  logic [9:0]         rad_r;
  logic signed [31:0] scx_r, scy_r, offx_r, offy_r, lax_r, lay_r;
  logic               dyn_r;

  logic signed [31:0] bx_r, by_r, bvx_r, bvy_r, bax_r, bay_r;
  logic signed [31:0] bx_nxt, by_nxt, bvx_nxt, bvy_nxt, bax_nxt, bay_nxt;
  logic [15:0]        hcnt_r, hcnt_nxt;
  logic               stop_r, stop_nxt;

  logic signed [31:0] px_r, py_r, pvx_r, pvy_r;
  logic signed [31:0] px_nxt, py_nxt, pvx_nxt, pvy_nxt;
  logic [15:0]        t_r, t_nxt;
  logic [9:0]         rpeg_r, rpeg_nxt;
  logic               last_r, last_nxt, mov_r, mov_nxt, hit_r, hit_nxt;

  logic signed [71:0] prod_r, acc_r, acc_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0]        tt_r, tt_nxt;
  logic [32:0]        nax_r, nax_nxt, nay_r, nay_nxt;
  logic               sx_r, sx_nxt, sy_r, sy_nxt;
  logic [63:0]        sqn_r, sqn_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [31:0]        mag_r, mag_nxt, rem_r, rem_nxt;
  logic [30:0]        q_r, q_nxt;
  logic               divy_r, divy_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [31:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [33:0] v1n_r, v1n_nxt, v2n_r, v2n_nxt, k_r, k_nxt;
  logic signed [34:0] dv_r, dv_nxt;

  ccr_pkg::ccr_res_t  res_r, res_nxt;
  logic               ovld_r, ovld_nxt;

  logic               in_fire, out_fire, cfg_fire;
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod_nxt;
  logic signed [71:0] pixx, pixy, adx, ady, rr;
  logic [10:0]        rsum;
  logic signed [32:0] nx, ny;
  logic [63:0]        try_v, rt_new;
  logic [32:0]        rem2;
  logic [64:0]        sh_a, sh_b, sh_d;
  logic [30:0]        q_new;
  logic signed [31:0] q_s, u_fin;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = (state_r == ccr_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = ovld_r;
  assign out_ch.hit            = res_r.hit;
  assign out_ch.peg_moving_out = res_r.peg_moving_out;
  assign out_ch.peg_vel_out_x  = res_r.peg_vel_out_x;
  assign out_ch.peg_vel_out_y  = res_r.peg_vel_out_y;
  assign out_ch.ball_pos_out_x = res_r.ball_pos_out_x;
  assign out_ch.ball_pos_out_y = res_r.ball_pos_out_y;
  assign out_ch.ball_vel_out_x = res_r.ball_vel_out_x;
  assign out_ch.ball_vel_out_y = res_r.ball_vel_out_y;
  assign out_ch.hits_total     = res_r.hits_total;

  // shared multiplier
  assign prod_nxt = mul_a * mul_b;

  // pixel projection, distances and contact radius
  assign pixx = (prod_r >>> FRAC_BITS) + 72'(offx_r);
  assign pixy = (prod_r >>> FRAC_BITS) + 72'(offy_r);
  assign adx  = dx_r[71] ? -dx_r : dx_r;
  assign ady  = dy_r[71] ? -dy_r : dy_r;
  assign rsum = {1'b0, rad_r} + {1'b0, rpeg_r};
  assign rr   = 72'(rsum) << FRAC_BITS;
  assign nx   = 33'(px_r) - 33'(bx_r);
  assign ny   = 33'(py_r) - 33'(by_r);

  // shared subtractor: square root trial and division step
  assign try_v = rt_r + bit_r;
  assign rem2  = {rem_r, 1'b0};
  assign sh_a  = (state_r == ccr_pkg::S_ROOT) ? {1'b0, sqn_r} : 65'(rem2);
  assign sh_b  = (state_r == ccr_pkg::S_ROOT) ? {1'b0, try_v} : 65'(mag_r);
  assign sh_d  = sh_a - sh_b;
  assign rt_new = sh_d[64] ? (rt_r >> 1) : ((rt_r >> 1) + bit_r);
  assign q_new = {q_r[29:0], ~sh_d[64]};
  assign q_s   = {1'b0, q_new};
  assign u_fin = (divy_r ? sy_r : sx_r) ? -q_s : q_s;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ccr_pkg::S_T0:  begin mul_a = 36'(t_r);   mul_b = 36'(t_r);   end
      ccr_pkg::S_T1:  begin mul_a = 36'(bax_r); mul_b = 36'(t_r);   end
      ccr_pkg::S_T2:  begin mul_a = 36'(bay_r); mul_b = 36'(t_r);   end
      ccr_pkg::S_T3:  begin mul_a = 36'(bvx_r); mul_b = 36'(t_r);   end
      ccr_pkg::S_T4:  begin mul_a = 36'(bax_r); mul_b = 36'(tt_r);  end
      ccr_pkg::S_T5:  begin mul_a = 36'(bvy_r); mul_b = 36'(t_r);   end
      ccr_pkg::S_T6:  begin mul_a = 36'(bay_r); mul_b = 36'(tt_r);  end
      ccr_pkg::S_P0:  begin mul_a = 36'(scx_r); mul_b = 36'(px_r);  end
      ccr_pkg::S_P1:  begin mul_a = 36'(scx_r); mul_b = 36'(bx_r);  end
      ccr_pkg::S_P2:  begin mul_a = 36'(scy_r); mul_b = 36'(py_r);  end
      ccr_pkg::S_P3:  begin mul_a = 36'(scy_r); mul_b = 36'(by_r);  end
      ccr_pkg::S_P5:  begin mul_a = adx[35:0];  mul_b = adx[35:0];  end
      ccr_pkg::S_P6:  begin mul_a = dy_r[35:0]; mul_b = dy_r[35:0]; end
      ccr_pkg::S_P7:  begin mul_a = rr[35:0];   mul_b = rr[35:0];   end
      ccr_pkg::S_SQ0: begin mul_a = 36'(nax_r[14:0]); mul_b = 36'(nax_r[14:0]); end
      ccr_pkg::S_SQ1: begin mul_a = 36'(nay_r[14:0]); mul_b = 36'(nay_r[14:0]); end
      ccr_pkg::S_D0:  begin mul_a = 36'(bvx_r); mul_b = 36'(ux_r);  end
      ccr_pkg::S_D1:  begin mul_a = 36'(bvy_r); mul_b = 36'(uy_r);  end
      ccr_pkg::S_D2:  begin mul_a = 36'(pvx_r); mul_b = 36'(ux_r);  end
      ccr_pkg::S_D3:  begin mul_a = 36'(pvy_r); mul_b = 36'(uy_r);  end
      ccr_pkg::S_D4:  begin mul_a = 36'(v1n_r); mul_b = ccr_pkg::RESTIT_HALF_Q30; end
      ccr_pkg::S_D6:  begin mul_a = -(36'(k_r)); mul_b = 36'(ux_r); end
      ccr_pkg::S_D7:  begin mul_a = -(36'(k_r)); mul_b = 36'(uy_r); end
      ccr_pkg::S_D8:  begin mul_a = 36'(dv_r);  mul_b = 36'(ux_r);  end
      ccr_pkg::S_D9:  begin mul_a = 36'(dv_r);  mul_b = 36'(uy_r);  end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    bx_nxt = bx_r;   by_nxt = by_r;   bvx_nxt = bvx_r; bvy_nxt = bvy_r;
    bax_nxt = bax_r; bay_nxt = bay_r; hcnt_nxt = hcnt_r; stop_nxt = stop_r;
    px_nxt = px_r;   py_nxt = py_r;   pvx_nxt = pvx_r; pvy_nxt = pvy_r;
    t_nxt = t_r;     rpeg_nxt = rpeg_r; last_nxt = last_r;
    mov_nxt = mov_r; hit_nxt = hit_r;
    acc_nxt = acc_r; dx_nxt = dx_r;   dy_nxt = dy_r;   tt_nxt = tt_r;
    nax_nxt = nax_r; nay_nxt = nay_r; sx_nxt = sx_r;   sy_nxt = sy_r;
    sqn_nxt = sqn_r; rt_nxt = rt_r;   bit_nxt = bit_r; mag_nxt = mag_r;
    rem_nxt = rem_r; q_nxt = q_r;     divy_nxt = divy_r; cnt_nxt = cnt_r;
    ux_nxt = ux_r;   uy_nxt = uy_r;   v1n_nxt = v1n_r; v2n_nxt = v2n_r;
    k_nxt = k_r;     dv_nxt = dv_r;
    res_nxt = res_r;
    ovld_nxt = ovld_r && !out_fire;

    case (state_r)
      ccr_pkg::S_IDLE: begin
        if (in_fire) begin
          px_nxt   = in_ch.pos_x;
          py_nxt   = in_ch.pos_y;
          pvx_nxt  = in_ch.vel_x;
          pvy_nxt  = in_ch.vel_y;
          t_nxt    = in_ch.time_step;
          rpeg_nxt = in_ch.peg_radius_px;
          last_nxt = in_ch.last_peg;
          mov_nxt  = in_ch.peg_moving;
          hit_nxt  = 1'b0;
          state_nxt = ccr_pkg::S_DONE;
          case (ccr_pkg::ccr_mode_t'(in_ch.mode))
            ccr_pkg::MODE_LOAD: begin
              bx_nxt  = in_ch.pos_x;
              by_nxt  = in_ch.pos_y;
              bvx_nxt = in_ch.vel_x;
              bvy_nxt = in_ch.vel_y;
              bax_nxt = '0;
              bay_nxt = '0;
            end
            ccr_pkg::MODE_TICK: begin
              if (in_ch.time_step != '0 && dyn_r) state_nxt = ccr_pkg::S_T0;
            end
            ccr_pkg::MODE_PEG: begin
              if (in_ch.last_peg) stop_nxt = 1'b0;
              if (!stop_r) begin
                if (!in_ch.peg_inside && in_ch.peg_moving) mov_nxt = 1'b0;
                else if (!in_ch.peg_moving) state_nxt = ccr_pkg::S_P0;
              end
            end
            default: state_nxt = ccr_pkg::S_DONE;
          endcase
        end
      end

      ccr_pkg::S_T0: state_nxt = ccr_pkg::S_T1;
      ccr_pkg::S_T1: begin
        tt_nxt = prod_r[31:0];
        state_nxt = ccr_pkg::S_T2;
      end
      ccr_pkg::S_T2: begin
        bvx_nxt = ccr_pkg::sat32(72'(bvx_r) + (prod_r >>> 16));
        state_nxt = ccr_pkg::S_T3;
      end
      ccr_pkg::S_T3: begin
        bvy_nxt = ccr_pkg::sat32(72'(bvy_r) + (prod_r >>> 16));
        state_nxt = ccr_pkg::S_T4;
      end
      ccr_pkg::S_T4: begin
        acc_nxt = prod_r >>> 16;
        state_nxt = ccr_pkg::S_T5;
      end
      ccr_pkg::S_T5: begin
        bx_nxt = ccr_pkg::sat32(72'(bx_r) + acc_r + (prod_r >>> 33));
        state_nxt = ccr_pkg::S_T6;
      end
      ccr_pkg::S_T6: begin
        acc_nxt = prod_r >>> 16;
        state_nxt = ccr_pkg::S_T7;
      end
      ccr_pkg::S_T7: begin
        by_nxt = ccr_pkg::sat32(72'(by_r) + acc_r + (prod_r >>> 33));
        state_nxt = ccr_pkg::S_DONE;
      end

      ccr_pkg::S_P0: state_nxt = ccr_pkg::S_P1;
      ccr_pkg::S_P1: begin
        dx_nxt = pixx;
        state_nxt = ccr_pkg::S_P2;
      end
      ccr_pkg::S_P2: begin
        dx_nxt = dx_r - pixx;
        state_nxt = ccr_pkg::S_P3;
      end
      ccr_pkg::S_P3: begin
        dy_nxt = pixy;
        state_nxt = ccr_pkg::S_P4;
      end
      ccr_pkg::S_P4: begin
        dy_nxt = dy_r - pixy;
        state_nxt = ccr_pkg::S_P5;
      end
      ccr_pkg::S_P5: begin
        // drop early when either axis alone is out of reach
        dy_nxt = ady;
        if (adx > rr || ady > rr) state_nxt = ccr_pkg::S_DONE;
        else state_nxt = ccr_pkg::S_P6;
      end
      ccr_pkg::S_P6: begin
        acc_nxt = prod_r;
        state_nxt = ccr_pkg::S_P7;
      end
      ccr_pkg::S_P7: begin
        acc_nxt = acc_r + prod_r;
        state_nxt = ccr_pkg::S_P8;
      end
      ccr_pkg::S_P8: begin
        state_nxt = ccr_pkg::S_DONE;
        if (acc_r <= prod_r) begin
          hit_nxt  = 1'b1;
          mov_nxt  = 1'b1;
          stop_nxt = !last_r;
          if (bay_r == '0) begin
            bax_nxt = lax_r;
            bay_nxt = lay_r;
          end
          if (hcnt_r != 16'hFFFF) hcnt_nxt = hcnt_r + 16'd1;
          sx_nxt  = nx[32];
          sy_nxt  = ny[32];
          nax_nxt = nx[32] ? 33'(-nx) : 33'(nx);
          nay_nxt = ny[32] ? 33'(-ny) : 33'(ny);
          if (nx != '0 || ny != '0) state_nxt = ccr_pkg::S_NORM;
        end
      end

      ccr_pkg::S_NORM: begin
        if (nax_r[32:15] != '0 || nay_r[32:15] != '0) begin
          nax_nxt = nax_r >> 1;
          nay_nxt = nay_r >> 1;
        end else begin
          state_nxt = ccr_pkg::S_SQ0;
        end
      end
      ccr_pkg::S_SQ0: state_nxt = ccr_pkg::S_SQ1;
      ccr_pkg::S_SQ1: begin
        acc_nxt = prod_r;
        state_nxt = ccr_pkg::S_SQ2;
      end
      ccr_pkg::S_SQ2: begin
        acc_nxt = acc_r + prod_r;
        sqn_nxt = {acc_nxt[31:0], 32'd0};
        rt_nxt  = '0;
        bit_nxt = 64'd1 << 62;
        cnt_nxt = '0;
        state_nxt = ccr_pkg::S_ROOT;
      end
      ccr_pkg::S_ROOT: begin
        if (!sh_d[64]) sqn_nxt = sh_d[63:0];
        rt_nxt  = rt_new;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          mag_nxt  = rt_new[31:0];
          rem_nxt  = {2'b00, nax_r[14:0], 15'd0};
          q_nxt    = '0;
          cnt_nxt  = '0;
          divy_nxt = 1'b0;
          state_nxt = ccr_pkg::S_DIV;
        end
      end
      ccr_pkg::S_DIV: begin
        rem_nxt = sh_d[64] ? rem2[31:0] : sh_d[31:0];
        q_nxt   = q_new;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          cnt_nxt = '0;
          q_nxt   = '0;
          if (!divy_r) begin
            ux_nxt   = u_fin;
            rem_nxt  = {2'b00, nay_r[14:0], 15'd0};
            divy_nxt = 1'b1;
          end else begin
            uy_nxt = u_fin;
            state_nxt = ccr_pkg::S_D0;
          end
        end
      end

      ccr_pkg::S_D0: state_nxt = ccr_pkg::S_D1;
      ccr_pkg::S_D1: begin
        acc_nxt = prod_r;
        state_nxt = ccr_pkg::S_D2;
      end
      ccr_pkg::S_D2: begin
        v1n_nxt = 34'(ccr_pkg::rnd30(acc_r + prod_r));
        state_nxt = ccr_pkg::S_D3;
      end
      ccr_pkg::S_D3: begin
        acc_nxt = prod_r;
        state_nxt = ccr_pkg::S_D4;
      end
      ccr_pkg::S_D4: begin
        v2n_nxt = 34'(ccr_pkg::rnd30(acc_r + prod_r));
        state_nxt = ccr_pkg::S_D5;
      end
      ccr_pkg::S_D5: begin
        k_nxt = 34'(ccr_pkg::rnd30(prod_r));
        state_nxt = ccr_pkg::S_D6;
      end
      ccr_pkg::S_D6: begin
        dv_nxt = 35'(k_r) - 35'(v2n_r);
        state_nxt = ccr_pkg::S_D7;
      end
      ccr_pkg::S_D7: begin
        bvx_nxt = ccr_pkg::sat32(72'(bvx_r) + ccr_pkg::rnd30(prod_r));
        state_nxt = ccr_pkg::S_D8;
      end
      ccr_pkg::S_D8: begin
        bvy_nxt = ccr_pkg::sat32(72'(bvy_r) + ccr_pkg::rnd30(prod_r));
        state_nxt = ccr_pkg::S_D9;
      end
      ccr_pkg::S_D9: begin
        pvx_nxt = ccr_pkg::sat32(72'(pvx_r) + ccr_pkg::rnd30(prod_r));
        state_nxt = ccr_pkg::S_D10;
      end
      ccr_pkg::S_D10: begin
        pvy_nxt = ccr_pkg::sat32(72'(pvy_r) + ccr_pkg::rnd30(prod_r));
        state_nxt = ccr_pkg::S_DONE;
      end

      ccr_pkg::S_DONE: begin
        // hold until the output register is free
        if (!ovld_r || out_fire) begin
          res_nxt.hit            = hit_r;
          res_nxt.peg_moving_out = mov_r;
          res_nxt.peg_vel_out_x  = pvx_r;
          res_nxt.peg_vel_out_y  = pvy_r;
          res_nxt.ball_pos_out_x = bx_r;
          res_nxt.ball_pos_out_y = by_r;
          res_nxt.ball_vel_out_x = bvx_r;
          res_nxt.ball_vel_out_y = bvy_r;
          res_nxt.hits_total     = hcnt_r;
          ovld_nxt  = 1'b1;
          state_nxt = ccr_pkg::S_IDLE;
        end
      end

      default: state_nxt = ccr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccr_pkg::S_IDLE;
      ovld_r  <= 1'b0;
      bx_r <= '0; by_r <= '0; bvx_r <= '0; bvy_r <= '0;
      bax_r <= '0; bay_r <= '0;
      hcnt_r <= '0;
      stop_r <= 1'b0;
      rad_r  <= 10'd8;
      scx_r  <= 32'sd65536;
      scy_r  <= 32'sd65536;
      offx_r <= '0; offy_r <= '0;
      lax_r  <= '0; lay_r  <= '0;
      dyn_r  <= 1'b1;
      cnt_r  <= '0;
      divy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      bx_r <= bx_nxt; by_r <= by_nxt; bvx_r <= bvx_nxt; bvy_r <= bvy_nxt;
      bax_r <= bax_nxt; bay_r <= bay_nxt;
      hcnt_r <= hcnt_nxt;
      stop_r <= stop_nxt;
      cnt_r  <= cnt_nxt;
      divy_r <= divy_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          ccr_pkg::REG_BALL_RADIUS: rad_r  <= cfg_ch.data[9:0];
          ccr_pkg::REG_SCALE_X:     scx_r  <= cfg_ch.data;
          ccr_pkg::REG_SCALE_Y:     scy_r  <= cfg_ch.data;
          ccr_pkg::REG_OFFSET_X:    offx_r <= cfg_ch.data;
          ccr_pkg::REG_OFFSET_Y:    offy_r <= cfg_ch.data;
          ccr_pkg::REG_LAUNCH_X:    lax_r  <= cfg_ch.data;
          ccr_pkg::REG_LAUNCH_Y:    lay_r  <= cfg_ch.data;
          ccr_pkg::REG_DYNAMIC:     dyn_r  <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pvx_r <= pvx_nxt; pvy_r <= pvy_nxt;
    t_r <= t_nxt; rpeg_r <= rpeg_nxt; last_r <= last_nxt;
    mov_r <= mov_nxt; hit_r <= hit_nxt;
    acc_r <= acc_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt; tt_r <= tt_nxt;
    nax_r <= nax_nxt; nay_r <= nay_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    sqn_r <= sqn_nxt; rt_r <= rt_nxt; bit_r <= bit_nxt; mag_r <= mag_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt;
    v1n_r <= v1n_nxt; v2n_r <= v2n_nxt; k_r <= k_nxt; dv_r <= dv_nxt;
    res_r <= res_nxt;
  end

endmodule
